@@ sv/olddq_pkg.sv @@
// ============================================================================
// olddq_pkg
// Shared codes and controller/datapath interface types for the ordered list
// deque with delete.
// ============================================================================
package olddq_pkg;

    // Request operation codes
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_REM_FRONT = 3'd2;
    localparam logic [2:0] OP_REM_BACK  = 3'd3;
    localparam logic [2:0] OP_REM_VALUE = 3'd4;

    // Response status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Datapath actions issued by the controller
    localparam logic [3:0] ACT_NONE       = 4'd0;
    localparam logic [3:0] ACT_INS_FRONT  = 4'd1;
    localparam logic [3:0] ACT_INS_BACK   = 4'd2;
    localparam logic [3:0] ACT_REJECT     = 4'd3;
    localparam logic [3:0] ACT_RD_FRONT   = 4'd4;
    localparam logic [3:0] ACT_RD_BACK    = 4'd5;
    localparam logic [3:0] ACT_FIN_FRONT  = 4'd6;
    localparam logic [3:0] ACT_FIN_BACK   = 4'd7;
    localparam logic [3:0] ACT_SCAN_START = 4'd8;
    localparam logic [3:0] ACT_SCAN_NEXT  = 4'd9;
    localparam logic [3:0] ACT_FIN_VALUE  = 4'd10;
    localparam logic [3:0] ACT_SH_RD      = 4'd11;
    localparam logic [3:0] ACT_SH_WR      = 4'd12;
    localparam logic [3:0] ACT_SH_LAST    = 4'd13;

    typedef struct packed {
        logic [3:0] act;
        logic [1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic match;
        logic scan_last;
        logic shift_last;
        logic rsp_valid;
    } dp_stat_t;

endpackage

@@ sv/olddq_ctrl.sv @@
// ============================================================================
// olddq_ctrl
// Request sequencer: decodes each accepted request and steps the datapath
// through reads, the value search and the closing shift.
// ============================================================================
module olddq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [2:0]          operation,
    input  logic                rsp_stall,
    input  olddq_pkg::dp_stat_t stat,
    output olddq_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDF   = 3'd1;
    localparam logic [2:0] S_RDB   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_free;
    logic       accept;

    // The response register is free if empty or being emptied this cycle.
    assign rsp_free  = !stat.rsp_valid || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) && rsp_free);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd.act    = olddq_pkg::ACT_NONE;
        cmd.status = olddq_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        olddq_pkg::OP_INS_FRONT:
                        begin
                            if (stat.full)
                            begin
                                cmd.act    = olddq_pkg::ACT_REJECT;
                                cmd.status = olddq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.act = olddq_pkg::ACT_INS_FRONT;
                            end
                        end
                        olddq_pkg::OP_INS_BACK:
                        begin
                            if (stat.full)
                            begin
                                cmd.act    = olddq_pkg::ACT_REJECT;
                                cmd.status = olddq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.act = olddq_pkg::ACT_INS_BACK;
                            end
                        end
                        olddq_pkg::OP_REM_FRONT:
                        begin
                            if (stat.count_zero)
                            begin
                                cmd.act    = olddq_pkg::ACT_REJECT;
                                cmd.status = olddq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.act    = olddq_pkg::ACT_RD_FRONT;
                                state_next = S_RDF;
                            end
                        end
                        olddq_pkg::OP_REM_BACK:
                        begin
                            if (stat.count_zero)
                            begin
                                cmd.act    = olddq_pkg::ACT_REJECT;
                                cmd.status = olddq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.act    = olddq_pkg::ACT_RD_BACK;
                                state_next = S_RDB;
                            end
                        end
                        olddq_pkg::OP_REM_VALUE:
                        begin
                            if (stat.count_zero)
                            begin
                                cmd.act    = olddq_pkg::ACT_REJECT;
                                cmd.status = olddq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.act    = olddq_pkg::ACT_SCAN_START;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // Unused codes leave the list alone and answer ok.
                            cmd.act    = olddq_pkg::ACT_REJECT;
                            cmd.status = olddq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_RDF:
            begin
                cmd.act    = olddq_pkg::ACT_FIN_FRONT;
                state_next = S_IDLE;
            end
            S_RDB:
            begin
                cmd.act    = olddq_pkg::ACT_FIN_BACK;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                priority if (stat.match && stat.scan_last)
                begin
                    cmd.act    = olddq_pkg::ACT_FIN_VALUE;
                    state_next = S_IDLE;
                end
                else if (stat.match)
                begin
                    cmd.act    = olddq_pkg::ACT_SH_RD;
                    state_next = S_SHIFT;
                end
                else if (stat.scan_last)
                begin
                    cmd.act    = olddq_pkg::ACT_REJECT;
                    cmd.status = olddq_pkg::ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.act = olddq_pkg::ACT_SCAN_NEXT;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_last)
                begin
                    cmd.act    = olddq_pkg::ACT_SH_LAST;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.act = olddq_pkg::ACT_SH_WR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/olddq_dp.sv @@
// ============================================================================
// olddq_dp
// Entry memory kept as a ring with a head pointer, occupancy count, search
// position, value comparator and the response register.
// ============================================================================
module olddq_dp
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  olddq_pkg::dp_cmd_t   cmd,
    output olddq_pkg::dp_stat_t  stat,
    input  logic signed [31:0]   value,
    input  logic                 rsp_stall,
    output logic                 rsp_valid,
    output logic [1:0]           status,
    output logic signed [31:0]   removed_value,
    output logic [CW-1:0]        entry_count
);

    localparam logic [CW+1:0] DEPTH_S = (CW + 2)'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    logic [31:0]       mem [DEPTH];
    logic [31:0]       rdata_reg;
    logic [31:0]       val_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     pos_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [1:0]        status_reg;
    logic [31:0]       removed_reg;
    logic [CW-1:0]     rsp_count_reg;

    logic              load;
    logic [1:0]        load_status;
    logic [31:0]       load_removed;
    logic [CW:0]       rd_off;
    logic [CW:0]       wr_off;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic              we;
    logic [31:0]       wdata;
    logic [CW:0]       pos_w;
    logic [CW:0]       count_w;

    // Ring position of the entry at list offset off.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW:0] off);
        logic [CW+1:0] sum;
        sum = {{(CW + 2 - AW){1'b0}}, h} + {1'b0, off};
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    assign pos_w   = {1'b0, pos_reg};
    assign count_w = {1'b0, count_reg};

    assign stat.count_zero = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(DEPTH));
    assign stat.match      = (rdata_reg == val_reg);
    assign stat.scan_last  = (pos_w + (CW + 1)'(1) == count_w);
    assign stat.shift_last = (pos_w + (CW + 1)'(2) == count_w);
    assign stat.rsp_valid  = rsp_valid_reg;

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        rd_off       = '0;
        wr_off       = '0;
        we           = 1'b0;
        wdata        = value;
        load         = 1'b0;
        load_status  = olddq_pkg::ST_OK;
        load_removed = '0;
        waddr        = phys(head_reg, wr_off);
        unique case (cmd.act)
            olddq_pkg::ACT_INS_FRONT:
            begin
                head_next  = (head_reg == '0) ? LAST_A : head_reg - AW'(1);
                count_next = count_reg + CW'(1);
                we         = 1'b1;
                load       = 1'b1;
            end
            olddq_pkg::ACT_INS_BACK:
            begin
                wr_off     = count_w;
                count_next = count_reg + CW'(1);
                we         = 1'b1;
                load       = 1'b1;
            end
            olddq_pkg::ACT_REJECT:
            begin
                load        = 1'b1;
                load_status = cmd.status;
            end
            olddq_pkg::ACT_RD_FRONT:
            begin
                rd_off = '0;
            end
            olddq_pkg::ACT_RD_BACK:
            begin
                rd_off = count_w - (CW + 1)'(1);
            end
            olddq_pkg::ACT_FIN_FRONT:
            begin
                head_next    = (head_reg == LAST_A) ? '0 : head_reg + AW'(1);
                count_next   = count_reg - CW'(1);
                load         = 1'b1;
                load_removed = rdata_reg;
            end
            olddq_pkg::ACT_FIN_BACK:
            begin
                count_next   = count_reg - CW'(1);
                load         = 1'b1;
                load_removed = rdata_reg;
            end
            olddq_pkg::ACT_SCAN_START:
            begin
                rd_off   = '0;
                pos_next = '0;
            end
            olddq_pkg::ACT_SCAN_NEXT:
            begin
                rd_off   = pos_w + (CW + 1)'(1);
                pos_next = pos_reg + CW'(1);
            end
            olddq_pkg::ACT_FIN_VALUE:
            begin
                count_next   = count_reg - CW'(1);
                load         = 1'b1;
                load_removed = val_reg;
            end
            olddq_pkg::ACT_SH_RD:
            begin
                rd_off = pos_w + (CW + 1)'(1);
            end
            olddq_pkg::ACT_SH_WR:
            begin
                // Read runs two entries ahead of the write that closes the gap.
                rd_off   = pos_w + (CW + 1)'(2);
                wr_off   = pos_w;
                wdata    = rdata_reg;
                we       = 1'b1;
                pos_next = pos_reg + CW'(1);
            end
            olddq_pkg::ACT_SH_LAST:
            begin
                wr_off       = pos_w;
                wdata        = rdata_reg;
                we           = 1'b1;
                count_next   = count_reg - CW'(1);
                load         = 1'b1;
                load_removed = val_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        if (cmd.act == olddq_pkg::ACT_INS_FRONT)
        begin
            waddr = head_next;
        end
        else
        begin
            waddr = phys(head_reg, wr_off);
        end
    end

    assign raddr = phys(head_reg, rd_off);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.act == olddq_pkg::ACT_SCAN_START)
        begin
            val_reg <= value;
        end
        if (load)
        begin
            status_reg    <= load_status;
            removed_reg   <= load_removed;
            rsp_count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = rsp_count_reg;

endmodule

@@ sv/ordered_list_deque_with_delete_unit.sv @@
// ============================================================================
// ordered_list_deque_with_delete_unit
// Bounded ordered list of signed 32-bit values with front/back insert and
// remove, and remove of the first entry equal to a given value.
// ============================================================================
// One request is handled at a time and each gives one response. Inserts,
// rejected requests (full, empty, unused code) reach the response register
// in the cycle after the transfer; remove front and remove back first read
// the entry through the registered read of the entry memory. Remove by value
// walks the single read port of the memory: it scans from the front until a
// match or the last entry, and after a match shifts each later entry one
// place toward the front to close the gap. A new request is taken once the
// previous one is finished and the response register is free or being
// emptied in the same cycle.
module ordered_list_deque_with_delete_unit
#(
    parameter int DEPTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [2:0]                       operation,
    input  logic signed [31:0]               value,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [1:0]                       status,
    output logic signed [31:0]               removed_value,
    output logic [$clog2(DEPTH + 1)-1:0]     entry_count
);

    olddq_pkg::dp_cmd_t  cmd;
    olddq_pkg::dp_stat_t stat;

    olddq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (operation),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    olddq_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .value         (value),
        .rsp_stall     (rsp_stall),
        .rsp_valid     (rsp_valid),
        .status        (status),
        .removed_value (removed_value),
        .entry_count   (entry_count)
    );

endmodule

@@ sv/olddq_checker.sv @@
// ============================================================================
// olddq_checker
// Port-level checks of the response channel against the list semantics.
// ============================================================================
module olddq_checker
#(
    parameter int DEPTH = 16
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_stall,
    input logic [1:0]                   status,
    input logic signed [31:0]           removed_value,
    input logic [$clog2(DEPTH + 1)-1:0] entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == olddq_pkg::ST_FULL) |-> entry_count == CW'(DEPTH))
        else $error("full reported while not at depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == olddq_pkg::ST_EMPTY) |-> entry_count == '0)
        else $error("empty reported with entries held");

    a_failed_removed: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == olddq_pkg::ST_EMPTY || status == olddq_pkg::ST_FULL
            || status == olddq_pkg::ST_NOT_FOUND)) |-> removed_value == 32'sd0)
        else $error("removed value not zero on a failed request");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status)
            && $stable(removed_value) && $stable(entry_count)))
        else $error("stalled response changed");

endmodule

bind ordered_list_deque_with_delete_unit olddq_checker #(
    .DEPTH (DEPTH)
) u_olddq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .removed_value (removed_value),
    .entry_count   (entry_count)
);

@@ tb/tb_ordered_list_deque_with_delete_unit.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_ordered_list_deque_with_delete_unit
// Self-checking testbench for the ordered list deque with delete. Requests are
// sent through the request channel with random gaps. A software copy of the
// list predicts each response. The response channel is stalled at random, and
// every accepted response is compared field by field with the oldest
// prediction.
// ============================================================================
module tb_ordered_list_deque_with_delete_unit;

    localparam int DEPTH        = 16;
    localparam int CW           = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1020;
    localparam int IDLE_LIMIT   = 1000;

    // Codes that the block does not use; it must answer them and change nothing.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed;
        logic [CW-1:0]      entries;
    } list_resp_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               req_valid     = 1'b0;
    logic               req_stall;
    logic [2:0]         operation     = 3'd0;
    logic signed [31:0] value         = 32'sd0;
    logic               rsp_valid;
    logic               rsp_stall     = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [CW-1:0]      entry_count;

    logic signed [31:0] held_values[$];
    list_resp_t         expected_responses[$];
    int                 error_count = 0;
    int                 idle_cycles = 0;
    int                 stall_left  = 0;
    bit                 calm        = 1'b0;

    ordered_list_deque_with_delete_unit #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .value         (value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .removed_value (removed_value),
        .entry_count   (entry_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none at all while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Applies one request to the list copy and returns the response it gives.
    function automatic list_resp_t apply_list_request(logic [2:0] op, logic signed [31:0] val);
        list_resp_t r;
        int         pos;
        r.status  = olddq_pkg::ST_OK;
        r.removed = 32'sd0;
        case (op)
            olddq_pkg::OP_INS_FRONT:
                if (held_values.size() >= DEPTH)
                    r.status = olddq_pkg::ST_FULL;
                else
                    held_values.push_front(val);
            olddq_pkg::OP_INS_BACK:
                if (held_values.size() >= DEPTH)
                    r.status = olddq_pkg::ST_FULL;
                else
                    held_values.push_back(val);
            olddq_pkg::OP_REM_FRONT:
                if (held_values.size() == 0)
                    r.status = olddq_pkg::ST_EMPTY;
                else
                    r.removed = held_values.pop_front();
            olddq_pkg::OP_REM_BACK:
                if (held_values.size() == 0)
                    r.status = olddq_pkg::ST_EMPTY;
                else
                    r.removed = held_values.pop_back();
            olddq_pkg::OP_REM_VALUE:
                if (held_values.size() == 0)
                    r.status = olddq_pkg::ST_EMPTY;
                else
                begin
                    // The front-most match goes; the back entry is searched as well.
                    r.status = olddq_pkg::ST_NOT_FOUND;
                    pos = 0;
                    while (pos < held_values.size() && r.status == olddq_pkg::ST_NOT_FOUND)
                    begin
                        if (held_values[pos] == val)
                        begin
                            r.removed = held_values[pos];
                            r.status  = olddq_pkg::ST_OK;
                            held_values.delete(pos);
                        end
                        pos++;
                    end
                end
            default: ;
        endcase
        r.entries = CW'(held_values.size());
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Called at the current rising edge; returns at the edge where the transfer happens.
    task automatic send_request(input logic [2:0] op, input logic signed [31:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        value     <= val;
        // Inputs only move at rising edges, so the stall seen at the falling edge
        // is the one that decides the next rising edge.
        do
            @(negedge clk);
        while (req_stall);
        @(posedge clk);
        expected_responses.push_back(apply_list_request(op, val));
    endtask

    task automatic check_response();
        list_resp_t want;
        if (expected_responses.size() == 0)
        begin
            report_mismatch($sformatf("response with nothing outstanding, status %0d", status));
            return;
        end
        want = expected_responses.pop_front();
        if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (removed_value !== want.removed)
            report_mismatch($sformatf("removed_value %0d, expected %0d",
                                      removed_value, want.removed));
        if (entry_count !== want.entries)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      entry_count, want.entries));
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            rsp_stall  <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (rsp_valid && !rsp_stall)
                check_response();
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [2:0] pick_operation(int insert_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        if (r < insert_pct)
            return $urandom_range(0, 1) ? olddq_pkg::OP_INS_FRONT : olddq_pkg::OP_INS_BACK;
        case ($urandom_range(0, 3))
            0:       return olddq_pkg::OP_REM_FRONT;
            1:       return olddq_pkg::OP_REM_BACK;
            default: return olddq_pkg::OP_REM_VALUE;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value(logic [2:0] op);
        int r;
        int near_zero;
        r = $urandom_range(0, 99);
        if (op == olddq_pkg::OP_REM_VALUE && held_values.size() > 0 && r < 70)
            return held_values[$urandom_range(0, held_values.size() - 1)];
        if (r < 80)
            return $urandom;
        if (r < 92)
        begin
            // A narrow pool gives duplicates, so the front-most match is exercised.
            near_zero = int'($urandom_range(0, 4)) - 2;
            return near_zero;
        end
        case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    task automatic test_empty_list();
        send_request(olddq_pkg::OP_REM_FRONT, 32'sd5);
        send_request(olddq_pkg::OP_REM_BACK, VAL_MAX);
        send_request(olddq_pkg::OP_REM_VALUE, 32'sd0);
        send_request(OP_SPARE_FIRST, VAL_MIN);
        send_request(OP_SPARE_LAST, -32'sd1);
    endtask

    task automatic test_only_entry();
        send_request(olddq_pkg::OP_INS_BACK, VAL_MIN);
        send_request(olddq_pkg::OP_REM_VALUE, VAL_MIN);
        send_request(olddq_pkg::OP_INS_FRONT, VAL_MAX);
        send_request(olddq_pkg::OP_REM_BACK, 32'sd0);
    endtask

    task automatic test_full_list();
        logic signed [31:0] corner_vals[4];
        int                 k;
        corner_vals[0] = VAL_MIN;
        corner_vals[1] = VAL_MAX;
        corner_vals[2] = 32'sd0;
        corner_vals[3] = -32'sd1;
        for (k = 0; k < DEPTH; k++)
            send_request(k[0] ? olddq_pkg::OP_INS_FRONT : olddq_pkg::OP_INS_BACK,
                         (k < 4) ? corner_vals[k] : $urandom);
        send_request(olddq_pkg::OP_INS_FRONT, 32'sd1);
        send_request(olddq_pkg::OP_INS_BACK, VAL_MAX);
        send_request(olddq_pkg::OP_REM_VALUE, held_values[held_values.size() - 1]);
        send_request(olddq_pkg::OP_REM_VALUE, 32'sh1234_5678);
    endtask

    task automatic test_random_traffic();
        int         sent;
        int         insert_pct;
        logic [2:0] op;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 2))
                0:       insert_pct = 80;
                1:       insert_pct = 20;
                default: insert_pct = 50;
            endcase
            repeat ($urandom_range(10, 60))
            begin
                op = pick_operation(insert_pct);
                send_request(op, pick_value(op));
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_only_entry();
        test_full_list();
        test_random_traffic();
        req_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/olddq_pkg.sv
sv/olddq_ctrl.sv
sv/olddq_dp.sv
sv/ordered_list_deque_with_delete_unit.sv
sv/olddq_checker.sv
tb/tb_ordered_list_deque_with_delete_unit.sv
